FILE: design/ftsg_pkg.sv
package ftsg_pkg;

	localparam int TIME_BITS_DEF     = 32;
	localparam int STEP_W            = 16;
	localparam int LIMIT_W           = 15;
	localparam int MASK_W            = 3;
	// divisor is a clamped magnitude times two or four
	localparam int DIV_W             = LIMIT_W + 2;
	localparam int SHIFT_XY          = 1;
	localparam int SHIFT_Z           = 2;
	localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = LIMIT_W'(2000);

	// request kinds carried in req_type
	localparam logic REQ_MOVE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// requests from the sequencer to one axis lane
	typedef struct packed {
		logic start;
		logic tick;
		logic stop;
	} lane_ctl_t;

	// what one axis lane reports back
	typedef struct packed {
		logic busy;
		logic running;
		logic pin;
	} lane_sts_t;

	// magnitude of a 16-bit two's complement step count
	function automatic logic [STEP_W-1:0] magnitude16(input logic [STEP_W-1:0] raw);
		logic [STEP_W-1:0] neg;
		neg = ~raw + STEP_W'(1);
		return raw[STEP_W-1] ? neg : raw;
	endfunction

endpackage

FILE: design/ftsg_if.sv
interface ftsg_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [ftsg_pkg::STEP_W-1:0]   steps_x;
	logic [ftsg_pkg::STEP_W-1:0]   steps_y;
	logic [ftsg_pkg::STEP_W-1:0]   steps_z;

	modport source (output valid, req_type, steps_x, steps_y, steps_z, input ready);
	modport sink (input valid, req_type, steps_x, steps_y, steps_z, output ready);
endinterface

interface ftsg_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          step_x;
	logic                          step_y;
	logic                          step_z;
	logic                          dir_x;
	logic                          dir_y;
	logic                          dir_z;
	logic [ftsg_pkg::MASK_W-1:0]   running_mask;

	modport source (output valid, step_x, step_y, step_z, dir_x, dir_y, dir_z,
		running_mask, input ready);
	modport sink (input valid, step_x, step_y, step_z, dir_x, dir_y, dir_z,
		running_mask, output ready);
endinterface

interface ftsg_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ftsg_pkg::LIMIT_W-1:0]  speed_limit;

	modport source (output valid, speed_limit, input ready);
	modport sink (input valid, speed_limit, output ready);
endinterface

FILE: design/ftsg_div.sv
module ftsg_div #(
	parameter int TIME_BITS = ftsg_pkg::TIME_BITS_DEF,
	parameter int DIV_W     = ftsg_pkg::DIV_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [TIME_BITS-1:0] dividend,
	input  logic [DIV_W-1:0]     divisor,
	output logic [TIME_BITS-1:0] quotient,
	output logic                 busy,
	output logic                 done
);

	localparam int CNT_W = $clog2(TIME_BITS + 1);

	logic [TIME_BITS-1:0] acc_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dsr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_W:0]       trial;
	logic [DIV_W:0]       diff;
	logic                 ge;

	// one restoring step per cycle, quotient bits shift in behind the dividend
	assign trial = {rem_q, acc_q[TIME_BITS-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TIME_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[TIME_BITS-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign quotient = acc_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

FILE: design/ftsg_lane.sv
module ftsg_lane #(
	parameter int TIME_BITS = ftsg_pkg::TIME_BITS_DEF,
	parameter int SHIFT     = ftsg_pkg::SHIFT_XY
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ftsg_pkg::lane_ctl_t            ctl,
	input  logic [TIME_BITS-1:0]           frame,
	input  logic [ftsg_pkg::STEP_W-1:0]    mag,
	input  logic [ftsg_pkg::LIMIT_W-1:0]   limit,
	output ftsg_pkg::lane_sts_t            sts
);

	localparam int DW = ftsg_pkg::DIV_W;
	localparam int LW = ftsg_pkg::LIMIT_W;

	logic [LW-1:0]        clamped;
	logic [DW-1:0]        divisor;
	logic                 div_start;
	logic [TIME_BITS-1:0] quo;
	logic                 div_busy;
	logic                 div_done;
	logic [TIME_BITS-1:0] phase_inc;

	logic [TIME_BITS-1:0] period_q;
	logic [TIME_BITS-1:0] phase_q;
	logic                 running_q;
	logic                 pin_q;

	assign clamped   = (mag > {1'b0, limit}) ? limit : mag[LW-1:0];
	assign divisor   = DW'(clamped) << SHIFT;
	assign div_start = ctl.start && (clamped != '0);
	assign phase_inc = phase_q + TIME_BITS'(1);

	ftsg_div #(
		.TIME_BITS (TIME_BITS),
		.DIV_W     (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (frame),
		.divisor  (divisor),
		.quotient (quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			pin_q     <= 1'b0;
			phase_q   <= '0;
		end else begin
			if (ctl.start && !div_start) begin
				running_q <= 1'b0;
			end else if (div_done) begin
				running_q <= 1'b1;
				phase_q   <= '0;
			end else if (ctl.tick) begin
				if (ctl.stop) begin
					running_q <= 1'b0;
				end else if (running_q) begin
					if (phase_inc >= period_q) begin
						pin_q   <= ~pin_q;
						phase_q <= '0;
					end else begin
						phase_q <= phase_inc;
					end
				end
			end
		end
	end

	// short frame floors the period at one
	always_ff @(posedge clk) begin
		if (div_done) begin
			period_q <= (quo == '0) ? TIME_BITS'(1) : quo;
		end
	end

	assign sts.busy    = div_busy || div_done;
	assign sts.running = running_q;
	assign sts.pin     = pin_q;

endmodule

FILE: design/frame_timed_three_axis_step_generator.sv
// channel | dir | beat carries                                   | taken when
// req     | in  | req_type, steps_x, steps_y, steps_z             | valid && ready
// rsp     | out | step_x/y/z, dir_x/y/z, running_mask            | valid && ready
// cfg     | in  | speed_limit                                     | valid && ready
//
// a tick beat is applied when taken; its result is held pending, then registered
// a command beat runs three lane dividers side by side, one quotient bit a cycle;
//   its result beat is offered once no lane divider is busy
// reset clears timers, pins, directions and all run flags; speed_limit goes to 2000
// a stalled rsp beat holds; one further req beat is taken while it waits
module frame_timed_three_axis_step_generator #(
	parameter int TIME_BITS = ftsg_pkg::TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ftsg_req_if.sink  req,
	ftsg_rsp_if.source rsp,
	ftsg_cfg_if.sink  cfg
);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_DIV  = 1'b1;

	// sequencer state
	logic [0:0]           state_q;
	logic                 pend_q;

	// frame timing
	logic [TIME_BITS-1:0] elapsed_q;
	logic [TIME_BITS-1:0] frame_q;
	logic [TIME_BITS-1:0] elapsed_nxt;
	logic                 frame_over;

	// direction pins and configuration
	logic                 dir_x_q;
	logic                 dir_y_q;
	logic                 dir_z_q;
	logic [ftsg_pkg::LIMIT_W-1:0] limit_q;

	// output register
	logic                 out_valid_q;
	logic                 step_x_q;
	logic                 step_y_q;
	logic                 step_z_q;
	logic                 odir_x_q;
	logic                 odir_y_q;
	logic                 odir_z_q;
	logic [ftsg_pkg::MASK_W-1:0] mask_q;

	logic                 req_acc;
	logic                 cmd_acc;
	logic                 tick_acc;
	logic                 out_load;
	logic                 lanes_busy;

	logic [ftsg_pkg::STEP_W-1:0] mag_x;
	logic [ftsg_pkg::STEP_W-1:0] mag_y;
	logic [ftsg_pkg::STEP_W-1:0] mag_z;

	ftsg_pkg::lane_ctl_t  ctl;
	ftsg_pkg::lane_sts_t  sts_x;
	ftsg_pkg::lane_sts_t  sts_y;
	ftsg_pkg::lane_sts_t  sts_z;

	// one item at a time; nothing new until the last result is in the output register
	assign req.ready = (state_q == ST_IDLE) && !pend_q;
	assign req_acc   = req.valid && req.ready;
	assign cmd_acc   = req_acc && (req.req_type == ftsg_pkg::REQ_MOVE);
	assign tick_acc  = req_acc && (req.req_type == ftsg_pkg::REQ_TICK);

	assign cfg.ready = 1'b1;

	// elapsed count saturates rather than wrapping
	assign elapsed_nxt = (&elapsed_q) ? elapsed_q : elapsed_q + TIME_BITS'(1);
	// elapsed beyond twice the frame, compared one bit wider
	assign frame_over  = {1'b0, elapsed_nxt} > {frame_q, 1'b0};

	assign mag_x = ftsg_pkg::magnitude16(req.steps_x);
	assign mag_y = ftsg_pkg::magnitude16(req.steps_y);
	assign mag_z = ftsg_pkg::magnitude16(req.steps_z);

	assign ctl.start = cmd_acc;
	assign ctl.tick  = tick_acc;
	assign ctl.stop  = frame_over;

	// the three axis lanes; each divider takes the frame just closed
	ftsg_lane #(.TIME_BITS(TIME_BITS), .SHIFT(ftsg_pkg::SHIFT_XY)) u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.frame  (elapsed_q),
		.mag    (mag_x),
		.limit  (limit_q),
		.sts    (sts_x)
	);

	ftsg_lane #(.TIME_BITS(TIME_BITS), .SHIFT(ftsg_pkg::SHIFT_XY)) u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.frame  (elapsed_q),
		.mag    (mag_y),
		.limit  (limit_q),
		.sts    (sts_y)
	);

	ftsg_lane #(.TIME_BITS(TIME_BITS), .SHIFT(ftsg_pkg::SHIFT_Z)) u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.frame  (elapsed_q),
		.mag    (mag_z),
		.limit  (limit_q),
		.sts    (sts_z)
	);

	assign lanes_busy = sts_x.busy || sts_y.busy || sts_z.busy;

	// merge: pending result moves into the output register once it is free
	assign out_load = pend_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			elapsed_q   <= '0;
			frame_q     <= '0;
			dir_x_q     <= 1'b0;
			dir_y_q     <= 1'b0;
			dir_z_q     <= 1'b0;
			limit_q     <= ftsg_pkg::SPEED_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.speed_limit;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						state_q   <= ST_DIV;
						frame_q   <= elapsed_q;
						elapsed_q <= '0;
						// direction follows the raw sign, before clamping
						dir_x_q   <= !req.steps_x[ftsg_pkg::STEP_W-1] && (req.steps_x != '0);
						dir_y_q   <= !req.steps_y[ftsg_pkg::STEP_W-1] && (req.steps_y != '0);
						dir_z_q   <= req.steps_z[ftsg_pkg::STEP_W-1];
					end else if (tick_acc) begin
						elapsed_q <= elapsed_nxt;
						pend_q    <= 1'b1;
					end
				end
				ST_DIV: begin
					if (!lanes_busy) begin
						state_q <= ST_IDLE;
						pend_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				pend_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			step_x_q <= sts_x.pin;
			step_y_q <= sts_y.pin;
			step_z_q <= sts_z.pin;
			odir_x_q <= dir_x_q;
			odir_y_q <= dir_y_q;
			odir_z_q <= dir_z_q;
			mask_q   <= {sts_z.running, sts_y.running, sts_x.running};
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.step_x       = step_x_q;
	assign rsp.step_y       = step_y_q;
	assign rsp.step_z       = step_z_q;
	assign rsp.dir_x        = odir_x_q;
	assign rsp.dir_y        = odir_y_q;
	assign rsp.dir_z        = odir_z_q;
	assign rsp.running_mask = mask_q;

	// a pending result never coexists with a running division
	a_pend_not_div: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && (state_q == ST_DIV)))
		else $error("result pending while dividing");

	// a command always leads into the divide phase
	a_cmd_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> (state_q == ST_DIV))
		else $error("command did not start division");

	// time does not move while the lanes divide
	a_elapsed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && $past(state_q == ST_DIV) |-> $stable(elapsed_q))
		else $error("elapsed count moved during division");

	// a new output beat only comes from a pending result
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pend_q))
		else $error("output beat without pending result");

endmodule
